// ===== src/smud_pkg.sv =====
// Package for the sorted merge union block: codes, defaults and control structs.
package smud_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int REQ_W          = 2;

  // request codes carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_RUN    = 2'd2
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic finish;
  } smud_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic any_left;
    logic step_stall;
    logic final_stall;
  } smud_stat_t;

endpackage

// ===== src/smud_in_if.sv =====
// Input channel interface: request code and value with valid/ready.
interface smud_in_if
  import smud_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic        [REQ_W-1:0]   req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ===== src/smud_out_if.sv =====
// Result channel interface: union value and last marker with valid/ready.
interface smud_out_if
  import smud_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] union_value;
  logic                      last_value;

  modport source (output valid, output union_value, output last_value, input ready);
  modport sink   (input valid, input union_value, input last_value, output ready);
endinterface

// ===== src/smud_ctrl.sv =====
// Controller state machine: decodes requests and sequences the merge walk.
module smud_ctrl
  import smud_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req,
  output logic             in_ready,
  input  smud_stat_t       stat,
  output smud_cmd_t        cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_req)
            REQ_LOAD_A: cmd.load_a = 1'b1;
            REQ_LOAD_B: cmd.load_b = 1'b1;
            REQ_RUN:    state_nxt  = ST_WALK;
            default:    ;  // unused code: dropped
          endcase
        end
      end
      ST_WALK: begin
        if (stat.any_left) begin
          cmd.step = !stat.step_stall;
        end else if (!stat.final_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/smud_dp.sv =====
// Datapath: list stores, counts, merge pointers, dedup holding stage, output register.
module smud_dp
  import smud_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [VALUE_W-1:0] in_value,
  input  smud_cmd_t                 cmd,
  output smud_stat_t                stat,
  smud_out_if.source                out_chan
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_WIDTH-1:0] mem_a [DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_b [DEPTH];

  logic signed [DATA_WIDTH-1:0] rd_a_r, rd_b_r;
  logic        [CW-1:0]         cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic        [CW-1:0]         i_r, i_nxt, j_r, j_nxt;
  logic signed [DATA_WIDTH-1:0] pend_r, pend_nxt;
  logic                         have_r, have_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0]    out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;

  logic signed [DATA_WIDTH-1:0] wr_val, cand;
  logic a_ok, b_ok, take_a, dup, out_free, wr_a, wr_b;

  assign wr_val   = DATA_WIDTH'(in_value);  // sign-extend or truncate
  assign wr_a     = cmd.load_a && (cnt_a_r < CW'(DEPTH));
  assign wr_b     = cmd.load_b && (cnt_b_r < CW'(DEPTH));

  assign a_ok     = i_r < cnt_a_r;
  assign b_ok     = j_r < cnt_b_r;
  assign take_a   = a_ok && (!b_ok || (rd_a_r <= rd_b_r));
  assign cand     = take_a ? rd_a_r : rd_b_r;
  assign dup      = have_r && (cand == pend_r);
  assign out_free = !out_valid_r || out_chan.ready;

  assign stat.any_left    = a_ok || b_ok;
  assign stat.step_stall  = have_r && !dup && !out_free;
  assign stat.final_stall = have_r && !out_free;

  always_comb begin
    cnt_a_nxt     = cnt_a_r + CW'(wr_a);
    cnt_b_nxt     = cnt_b_r + CW'(wr_b);
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (cmd.step) begin
      if (take_a) begin
        i_nxt = i_r + CW'(1);
      end else begin
        j_nxt = j_r + CW'(1);
      end
      if (!dup) begin
        if (have_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = VALUE_W'(pend_r);
          out_last_nxt  = 1'b0;
        end
        pend_nxt = cand;
        have_nxt = 1'b1;
      end
    end
    if (cmd.finish) begin
      if (have_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = VALUE_W'(pend_r);
        out_last_nxt  = 1'b1;
      end
      have_nxt  = 1'b0;
      i_nxt     = '0;
      j_nxt     = '0;
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // list stores: one write port, registered read following the next pointer
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= wr_val;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= wr_val;
    end
    rd_a_r <= mem_a[i_nxt[AW-1:0]];
    rd_b_r <= mem_b[j_nxt[AW-1:0]];
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.union_value = out_data_r;
  assign out_chan.last_value  = out_last_r;

endmodule

// ===== src/sorted_merge_union_dedup.sv =====
// A run walks one element per cycle except when a new distinct value meets a full
//   output register; a distinct value is held until the next one or the finish.
// Throughput: one load transaction per cycle while idle; during a run one element per
//   cycle, set by the single read port of each list store and the dedup holding stage.
// Reset (rst_n, synchronous): counts, pointers and output valid clear; store contents
//   stay undefined until written and need no clearing pass.
module sorted_merge_union_dedup
  import smud_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  smud_in_if.sink    in_chan,
  smud_out_if.source out_chan
);

  // Controller takes input transactions only while idle; a run keeps it in the walk
  // state until the final value has moved into the output register.
  smud_cmd_t  cmd;
  smud_stat_t stat;

  smud_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_req   (in_chan.req_type),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: the merge compares the two store heads, a holding register keeps the
  // newest distinct value so the last marker can be set once the walk runs dry.
  smud_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_chan.value),
    .cmd      (cmd),
    .stat     (stat),
    .out_chan (out_chan)
  );

endmodule

// ===== sim/sorted_merge_union_dedup_tb.sv =====
// Self-checking testbench for the sorted merge union block: directed table, then random lists.
module sorted_merge_union_dedup_tb;
  import smud_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int MAX_LEN     = DEPTH + 4;     // lists run a few past DEPTH to hit the drop path
  localparam int DIR_ROWS    = 24;
  localparam int ITEMS_RAND  = 406;           // loads plus runs in the random part
  localparam int TAIL_ITEMS  = 50;            // last stretch runs without any idling
  localparam int LONG_HOLD   = 150;           // receiver hold-off for the back-pressure case
  localparam int SETTLE      = 80;            // outlasts a walk over two full lists plus the output register
  localparam int STALL_LIMIT = 2000;
  localparam int SHOW_MAX    = 10;

  // request code 3 has no enum member; the block must ignore it
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // expectations come from the predictor
    CHK_NONE,    // a run that must give no union value
    CHK_ONE      // a run that must give exactly exp, with last set
  } chk_t;

  // how a random sequence fills its two lists
  typedef enum int {
    GEN_SPREAD,  // ascending, random base and mixed step sizes
    GEN_DUPS,    // ascending, tight range around zero, many repeats
    GEN_EDGES,   // ascending from the most negative value, jumps to the top
    GEN_NOISE    // no ordering at all
  } gen_t;

  typedef struct packed {
    logic [REQ_W-1:0]          req;
    logic signed [VALUE_W-1:0] val;
    chk_t                      chk;
    logic signed [VALUE_W-1:0] exp;
  } dir_row_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic                      last;
  } union_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  smud_in_if  in_chan ();
  smud_out_if out_chan ();

  sorted_merge_union_dedup u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Directed table. Typed expectations only where obvious: empty runs,
  // single extremes and a pair of equal heads collapsing to one value.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{REQ_RUN,    32'sh0000_0000, CHK_NONE,  32'sh0000_0000},  // run on empty lists
    '{REQ_LOAD_A, 32'sh8000_0000, CHK_MODEL, 32'sh0000_0000},
    '{REQ_RUN,    32'sh0000_0000, CHK_ONE,   32'sh8000_0000},  // A only, most negative
    '{REQ_LOAD_B, 32'sh7FFF_FFFF, CHK_MODEL, 32'sh0000_0000},
    '{REQ_RUN,    32'sh0000_0000, CHK_ONE,   32'sh7FFF_FFFF},  // B only, most positive
    '{REQ_LOAD_A, 32'shFFFF_FFFF, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_B, 32'shFFFF_FFFF, CHK_MODEL, 32'sh0000_0000},
    '{REQ_RUN,    32'sh0000_0000, CHK_ONE,   32'shFFFF_FFFF},  // equal heads dedup
    '{REQ_UNUSED, 32'sh5A5A_A5A5, CHK_MODEL, 32'sh0000_0000},  // ignored code
    '{REQ_RUN,    32'sh0000_0000, CHK_NONE,  32'sh0000_0000},  // nothing was loaded
    '{REQ_LOAD_A, 32'sh0000_0005, CHK_MODEL, 32'sh0000_0000},  // A descending
    '{REQ_LOAD_A, 32'sh0000_0003, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_B, 32'sh0000_0004, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_B, 32'sh0000_0004, CHK_MODEL, 32'sh0000_0000},  // repeat inside B
    '{REQ_RUN,    32'sh0000_0000, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_A, 32'sh8000_0000, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_B, 32'sh7FFF_FFFF, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_A, 32'sh7FFF_FFFF, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_B, 32'sh8000_0000, CHK_MODEL, 32'sh0000_0000},  // B out of order
    '{REQ_RUN,    32'sh0000_0000, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_B, 32'sh0000_0000, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_A, 32'sh0000_0000, CHK_MODEL, 32'sh0000_0000},
    '{REQ_LOAD_B, 32'sh0000_0001, CHK_MODEL, 32'sh0000_0000},  // B tail after A drains
    '{REQ_RUN,    32'sh0000_0000, CHK_MODEL, 32'sh0000_0000}
  };

  // predictor state: the two stores and their fill counts
  logic signed [VALUE_W-1:0] stored_a [DEPTH];
  logic signed [VALUE_W-1:0] stored_b [DEPTH];
  int fill_a;
  int fill_b;

  union_beat_t union_scratch [$];   // values one transaction produces
  union_beat_t union_expect  [$];   // values still owed by the block

  // check mode travels with the input transaction, driven alongside it
  chk_t                      drv_chk;
  logic signed [VALUE_W-1:0] drv_exp;

  bit idle_on;
  int hold_reqs;
  int hold_seen;
  int rx_gap;
  int rx_hold;
  int idle_cycles;
  int mismatches;
  int items_sent;

  // coverage tallies for the summary line
  int n_loads, n_dropped, n_unused, n_runs, n_empty, n_checked, widest;

  // Predictor: applies one transaction to the local stores and leaves the
  // union values it produces in union_scratch.
  function automatic void predict_union(logic [REQ_W-1:0] req, logic signed [VALUE_W-1:0] v);
    int i;
    int j;
    bit have;
    logic signed [VALUE_W-1:0] pick;
    logic signed [VALUE_W-1:0] prev;
    union_beat_t tail;
    union_scratch.delete();
    case (req)
      REQ_LOAD_A: begin
        n_loads++;
        if (fill_a < DEPTH) begin
          stored_a[fill_a] = v;
          fill_a++;
        end else begin
          n_dropped++;
        end
      end
      REQ_LOAD_B: begin
        n_loads++;
        if (fill_b < DEPTH) begin
          stored_b[fill_b] = v;
          fill_b++;
        end else begin
          n_dropped++;
        end
      end
      REQ_RUN: begin
        n_runs++;
        i = 0;
        j = 0;
        have = 1'b0;
        prev = '0;
        // two-pointer walk; A wins ties, and the tails drain once one side runs out
        while (i < fill_a || j < fill_b) begin
          if (j >= fill_b || (i < fill_a && stored_a[i] <= stored_b[j])) begin
            pick = stored_a[i];
            i++;
          end else begin
            pick = stored_b[j];
            j++;
          end
          if (!have || pick != prev)
            union_scratch.insert(union_scratch.size(), '{pick, 1'b0});
          have = 1'b1;
          prev = pick;
        end
        if (union_scratch.size() > 0) begin
          tail = union_scratch.pop_back();
          tail.last = 1'b1;
          union_scratch.insert(union_scratch.size(), tail);
        end else begin
          n_empty++;
        end
        if (union_scratch.size() > widest) widest = union_scratch.size();
        fill_a = 0;
        fill_b = 0;
      end
      default: n_unused++;
    endcase
  endfunction

  task automatic flag_mismatch(string what, union_beat_t exp, union_beat_t got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("mismatch %0d @%0t: %s exp val=%0d last=%0b got val=%0d last=%0b",
               mismatches, $realtime, what, exp.val, exp.last, got.val, got.last);
  endtask

  // Scoreboard: both channels are sampled at the same edge in one process,
  // so a prediction and its check never race each other.
  always @(posedge clk) begin
    union_beat_t exp;
    union_beat_t got;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        predict_union(in_chan.req_type, in_chan.value);
        case (drv_chk)
          CHK_MODEL:
            foreach (union_scratch[k])
              union_expect.insert(union_expect.size(), union_scratch[k]);
          CHK_ONE:   union_expect.insert(union_expect.size(), '{drv_exp, 1'b1});
          default:   ;  // CHK_NONE: nothing owed
        endcase
      end
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.union_value, out_chan.last_value};
        if (union_expect.size() == 0) begin
          flag_mismatch("unexpected transaction", '0, got);
        end else begin
          exp = union_expect.pop_front();
          if (got.val !== exp.val || got.last !== exp.last)
            flag_mismatch("field", exp, got);
          n_checked++;
        end
      end
    end
  end

  // Receiver pacing: short random stalls, plus one long hold-off on request
  // so the block backs up and stops taking new transactions.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      rx_hold = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_chan.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_chan.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 4) - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transaction on either side.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d values owed",
               idle_cycles, union_expect.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transaction; an optional short gap first. valid only drops
  // inside the gap, so it is never lowered and raised in one step.
  task automatic send_item(logic [REQ_W-1:0] req, logic signed [VALUE_W-1:0] val,
                           chk_t chk, logic signed [VALUE_W-1:0] exp_v);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= req;
    in_chan.value    <= val;
    drv_chk          <= chk;
    drv_exp          <= exp_v;
    @(posedge clk);
    while (!(in_chan.valid && in_chan.ready)) @(posedge clk);
  endtask

  // Stop offering and wait until every owed union value has come back.
  // The extra edge lets the scoreboard record the last accepted run first.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (union_expect.size() != 0) @(posedge clk);
  endtask

  // One random sequence: build lists A and B, load them interleaved with
  // an occasional ignored code, then run the merge (unless skipped, which
  // lets lists carry over into the next sequence).
  task automatic merge_seq(int na, int nb, gen_t mode, bit skip_run);
    logic signed [VALUE_W-1:0] la [MAX_LEN];
    logic signed [VALUE_W-1:0] lb [MAX_LEN];
    longint v;
    int ia, ib, sa, sb, pick;
    bit put_a, put_b;
    ia = 0;
    ib = 0;
    case (mode)
      GEN_DUPS:  v = longint'(int'($urandom_range(0, 6)) - 3);
      GEN_EDGES: v = -64'sd2147483648;
      default:   v = longint'(int'($urandom));
    endcase
    // walk one ascending value stream and deal it to A, B or both,
    // so cross-list and in-list duplicates both show up
    while (ia < na || ib < nb) begin
      pick  = $urandom_range(0, 2);
      put_a = ia < na && (pick != 1 || ib >= nb);
      put_b = ib < nb && (pick != 0 || ia >= na);
      if (mode == GEN_NOISE) v = longint'(int'($urandom));
      if (put_a) begin
        la[ia] = v[VALUE_W-1:0];
        ia++;
      end
      if (mode == GEN_NOISE) v = longint'(int'($urandom));
      if (put_b) begin
        lb[ib] = v[VALUE_W-1:0];
        ib++;
      end
      case (mode)
        GEN_DUPS:  v += $urandom_range(0, 1);
        GEN_EDGES: v += ($urandom_range(0, 3) == 0) ? 64'sh0000_0000_FFFF_FFFF
                                                    : longint'($urandom_range(0, 1));
        GEN_SPREAD: v += $urandom_range(0, 1) ? longint'($urandom_range(0, 2))
                                              : longint'($urandom >> $urandom_range(1, 31));
        default:   ;
      endcase
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
    sa = 0;
    sb = 0;
    while (sa < na || sb < nb) begin
      if ($urandom_range(0, 15) == 0)
        send_item(REQ_UNUSED, $urandom, CHK_MODEL, '0);
      if (sb >= nb || (sa < na && $urandom_range(0, 1))) begin
        send_item(REQ_LOAD_A, la[sa], CHK_MODEL, '0);
        sa++;
      end else begin
        send_item(REQ_LOAD_B, lb[sb], CHK_MODEL, '0);
        sb++;
      end
      items_sent++;
    end
    if (!skip_run) begin
      send_item(REQ_RUN, $urandom, CHK_MODEL, '0);
      items_sent++;
    end
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH - 4, MAX_LEN)
                                       : $urandom_range(0, 8);
  endfunction

  initial begin
    int s;
    int r;
    int na;
    int nb;
    gen_t mode;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.req_type <= REQ_LOAD_A;
    in_chan.value    <= '0;
    drv_chk          <= CHK_MODEL;
    drv_exp          <= '0;
    idle_on          = 1'b1;
    hold_reqs        <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tab[k])
      send_item(dir_tab[k].req, dir_tab[k].val, dir_tab[k].chk, dir_tab[k].exp);

    // random sequences
    s = 0;
    while (items_sent < ITEMS_RAND) begin
      if (items_sent >= ITEMS_RAND - TAIL_ITEMS)
        idle_on = 1'b0;
      else
        idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 7);
      mode = (r < 4) ? GEN_SPREAD : (r < 6) ? GEN_DUPS : (r == 6) ? GEN_EDGES : GEN_NOISE;
      na = pick_len();
      nb = pick_len();
      if (s == 0) begin
        // both lists overfilled: the surplus loads must be dropped
        na = MAX_LEN;
        nb = DEPTH + 1;
        mode = GEN_SPREAD;
      end
      if (s == 3) begin
        // long receiver hold-off while the sender keeps offering
        hold_reqs <= hold_reqs + 1;
        na = DEPTH - 2;
        nb = DEPTH - 2;
      end
      merge_seq(na, nb, mode, s > 0 && $urandom_range(0, 9) == 0);
      if (s == 6) drain_results();
      s++;
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (union_expect.size() != 0) begin
      mismatches += union_expect.size();
      $display("%0d union values never arrived", union_expect.size());
    end

    $display("covered %0d loads (%0d dropped on full lists), %0d ignored codes",
             n_loads, n_dropped, n_unused);
    $display("covered %0d merges (%0d empty, widest %0d values), %0d values checked",
             n_runs, n_empty, widest, n_checked);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
